// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge out of reset
`define CFTP_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CFTP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`else

`define CFTP_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define CFTP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/cftp_pkg.sv =====
// ---------------------------------------------------------------------------
// cftp_pkg
// types, character codes and helpers of the can frame text parser
// ---------------------------------------------------------------------------
`default_nettype none

package cftp_pkg;

  // character codes
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UP_R  = 8'h52;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] UP_A_OFS = 8'h37;
  localparam logic [7:0] LO_A_OFS = 8'h57;

  // hex decode gives this for a non-hex character
  localparam logic [4:0] HEX_INVALID    = 5'd16;
  localparam logic [4:0] REMOTE_LEN_MAX = 5'd8;

  localparam logic [3:0] ID_SHORT_DIGITS = 4'd3;
  localparam logic [3:0] ID_LONG_DIGITS  = 4'd8;

  localparam logic [6:0] FD_MAX_BYTES      = 7'd64;
  localparam logic [6:0] CLASSIC_MAX_BYTES = 7'd8;
  localparam logic [7:0] WORD_BYTES_M1     = 8'd7;

  localparam int ID_EXT_BIT = 31;
  localparam int ID_RTR_BIT = 30;
  localparam int ID_ERR_BIT = 29;

  // result status codes
  localparam logic [1:0] ST_MALFORMED = 2'd0;
  localparam logic [1:0] ST_CLASSIC   = 2'd1;
  localparam logic [1:0] ST_FD        = 2'd2;

  // payload store: two banks of eight 64-bit rows
  localparam int STORE_ROWS   = 16;
  localparam int STORE_ADDR_W = 4;

  // finished frame handed from parser to emitter
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] can_id;
    logic [6:0]  frame_len;
    logic [3:0]  fd_flags;
    logic [3:0]  nwords;
    logic        bank;
  } frame_desc_t;

  // one byte write into the payload store
  typedef struct packed {
    logic                    en;
    logic [STORE_ADDR_W-1:0] addr;
    logic [2:0]              lane;
    logic [7:0]              data;
  } store_wr_t;

  // emitter occupancy seen by the parser and the checks
  typedef struct packed {
    logic act_valid;
    logic hold_full;
  } emit_stat_t;

  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] v;
    if (ch >= CH_0 && ch <= CH_9) begin
      v = 5'(ch - CH_0);
    end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
      v = 5'(ch - UP_A_OFS);
    end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
      v = 5'(ch - LO_A_OFS);
    end else begin
      v = HEX_INVALID;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cftp_if.sv =====
// ---------------------------------------------------------------------------
// cftp_if
// valid/ready channels of the can frame text parser
// ---------------------------------------------------------------------------
`default_nettype none

interface cftp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_text;

  modport source (output valid, output character, output end_of_text, input ready);
  modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

interface cftp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] can_id;
  logic [6:0]  frame_len;
  logic [3:0]  fd_flags;
  logic        is_data_word;
  logic [2:0]  word_index;
  logic [63:0] data_word;
  logic        last;

  modport source (output valid, output status, output can_id, output frame_len,
                  output fd_flags, output is_data_word, output word_index,
                  output data_word, output last, input ready);
  modport sink   (input valid, input status, input can_id, input frame_len,
                  input fd_flags, input is_data_word, input word_index,
                  input data_word, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/can_frame_text_parser_unit.sv =====
// ---------------------------------------------------------------------------
// can_frame_text_parser_unit
// streaming decoder of can frame text '<id>#<data>' into header and payload
// ---------------------------------------------------------------------------
// The input takes one character per beat, the final character of a frame
// text marked by end_of_text, and accepts one beat every cycle. The id is
// three or eight hex digits; after '#' comes an 'R'/'r' remote form with an
// optional length digit, a '##' fd form with a flag nibble and up to 64
// bytes, or up to 8 hex byte pairs each optionally led by one '.'. Once the
// frame ends, the output gives one header beat and then one beat per packed
// 64-bit payload word, one beat per cycle while the sink is ready, so a
// frame produces 1 to 9 beats with the last one flagged. A malformed frame
// gives one beat: status 0, last set, other fields zero. The payload store
// has two banks, so the next frame is parsed while the previous one is still
// being sent; the input stalls only when a second finished frame has to wait
// behind one still being sent, and runs again in the cycle after that frame's
// last beat is loaded into the output register. No clearing pass after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module can_frame_text_parser_unit
  import cftp_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  cftp_in_if.sink     in_chan,
  cftp_out_if.source  out_chan
);

  `include "assert_macros.svh"

  // parser to emitter hand-off
  frame_desc_t             desc;
  logic                    desc_valid;
  emit_stat_t              emit_st;

  // payload store ports
  store_wr_t               st_wr;
  logic [STORE_ADDR_W-1:0] st_rd_addr;
  logic [63:0]             st_rd_data;

  // character decode and frame state
  cftp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_chan),
    .stat       (emit_st),
    .wr         (st_wr),
    .desc       (desc),
    .desc_valid (desc_valid)
  );

  // payload bytes, written by the parser, read a word at a time
  cftp_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // header and word beats through the output register
  cftp_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc       (desc),
    .desc_valid (desc_valid),
    .stat       (emit_st),
    .rd_addr    (st_rd_addr),
    .rd_data    (st_rd_data),
    .out_ch     (out_chan)
  );

  // a frame waits in the holding slot only behind one being sent
  `CFTP_ASSERT_IMPLIES(a_hold_behind_act, clk, rst_n, emit_st.hold_full, emit_st.act_valid, "hold slot full with no active frame")

  // a malformed frame is one header beat alone
  `CFTP_ASSERT_IMPLIES(a_malformed_single, clk, rst_n, out_chan.valid && out_chan.status == ST_MALFORMED, out_chan.last && !out_chan.is_data_word, "malformed frame beat not single")

  // a word beat that is not last leaves more payload behind it
  `CFTP_ASSERT_IMPLIES(a_word_more_bytes, clk, rst_n, out_chan.valid && out_chan.is_data_word && !out_chan.last, (out_chan.frame_len > {1'b0, out_chan.word_index, 3'b111}), "word beat not last but payload ends")

endmodule

`default_nettype wire

// ===== rtl/cftp_store.sv =====
// ---------------------------------------------------------------------------
// cftp_store
// payload byte store, two banks of eight 64-bit rows with byte lanes
// ---------------------------------------------------------------------------
`default_nettype none

module cftp_store
  import cftp_pkg::*;
(
  input  wire                    clk,
  input  store_wr_t              wr,
  input  wire [STORE_ADDR_W-1:0] rd_addr,
  output logic [63:0]            rd_data
);

  logic [63:0] mem [STORE_ROWS];

  // registered read, data follows the address in the next cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr][wr.lane*8 +: 8] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/cftp_parser.sv =====
// ---------------------------------------------------------------------------
// cftp_parser
// per-character frame text decode, one beat per cycle while the emitter's holding slot is free
// ---------------------------------------------------------------------------
`default_nettype none

module cftp_parser
  import cftp_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  cftp_in_if.sink     in_ch,
  input  emit_stat_t  stat,
  output store_wr_t   wr,
  output frame_desc_t desc,
  output logic        desc_valid
);

  typedef enum logic [2:0] {
    PH_ID, PH_AFTER_DELIM, PH_REMOTE_LEN, PH_FD_FLAGS,
    PH_DATA_START, PH_DATA_DOT, PH_DATA_LOW, PH_IGNORE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CLASSIC, KIND_FD, KIND_REMOTE
  } kind_t;

  phase_t      phase_r, phase_nxt;
  kind_t       kind_r, kind_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [31:0] id_r, id_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic [6:0]  bc_r, bc_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic        err_r, err_nxt;
  logic        bank_r, bank_nxt;

  logic        accept;
  logic [4:0]  nib;
  logic        is_hex;
  logic [6:0]  limit;
  logic [6:0]  bc_inc;
  logic [7:0]  len_round;
  logic        bad;

  assign in_ch.ready = !stat.hold_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign nib         = hex_value(in_ch.character);
  assign is_hex      = !nib[4];
  assign limit       = (kind_r == KIND_FD) ? FD_MAX_BYTES : CLASSIC_MAX_BYTES;
  assign bc_inc      = bc_r + 7'd1;

  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    pos_nxt    = pos_r;
    id_nxt     = id_r;
    hi_nxt     = hi_r;
    bc_nxt     = bc_r;
    flags_nxt  = flags_r;
    err_nxt    = err_r;
    bank_nxt   = bank_r;
    wr         = '0;
    desc       = '0;
    desc_valid = 1'b0;
    bad        = 1'b0;
    len_round  = '0;

    if (accept && !err_r) begin
      case (phase_r)
        PH_ID: begin
          if (pos_r == ID_SHORT_DIGITS && in_ch.character == CH_HASH) begin
            phase_nxt = PH_AFTER_DELIM;
            pos_nxt   = pos_r + 4'd1;
          end else if (pos_r == ID_LONG_DIGITS) begin
            if (in_ch.character != CH_HASH) begin
              err_nxt = 1'b1;
            end else begin
              if (!id_r[ID_ERR_BIT]) id_nxt[ID_EXT_BIT] = 1'b1;
              phase_nxt = PH_AFTER_DELIM;
              pos_nxt   = pos_r + 4'd1;
            end
          end else if (!is_hex) begin
            err_nxt = 1'b1;
          end else begin
            id_nxt  = {id_r[27:0], nib[3:0]};
            pos_nxt = pos_r + 4'd1;
          end
        end
        PH_AFTER_DELIM, PH_DATA_START: begin
          if (phase_r == PH_AFTER_DELIM &&
              (in_ch.character == CH_UP_R || in_ch.character == CH_LO_R)) begin
            kind_nxt            = KIND_REMOTE;
            id_nxt[ID_RTR_BIT]  = 1'b1;
            phase_nxt           = PH_REMOTE_LEN;
          end else if (phase_r == PH_AFTER_DELIM && in_ch.character == CH_HASH) begin
            kind_nxt  = KIND_FD;
            phase_nxt = PH_FD_FLAGS;
          end else if (in_ch.character == CH_DOT) begin
            phase_nxt = PH_DATA_DOT;
          end else if (!is_hex) begin
            err_nxt = 1'b1;
          end else begin
            hi_nxt    = nib[3:0];
            phase_nxt = PH_DATA_LOW;
          end
        end
        PH_REMOTE_LEN: begin
          // a non-digit leaves the length at zero
          if (nib <= REMOTE_LEN_MAX) bc_nxt = {3'b000, nib[3:0]};
          phase_nxt = PH_IGNORE;
        end
        PH_FD_FLAGS: begin
          if (!is_hex) begin
            err_nxt = 1'b1;
          end else begin
            flags_nxt = nib[3:0];
            phase_nxt = PH_DATA_START;
          end
        end
        PH_DATA_DOT: begin
          if (!is_hex) begin
            err_nxt = 1'b1;
          end else begin
            hi_nxt    = nib[3:0];
            phase_nxt = PH_DATA_LOW;
          end
        end
        PH_DATA_LOW: begin
          if (!is_hex) begin
            err_nxt = 1'b1;
          end else begin
            wr.en     = 1'b1;
            wr.addr   = {bank_r, bc_r[5:3]};
            wr.lane   = bc_r[2:0];
            wr.data   = {hi_r, nib[3:0]};
            bc_nxt    = bc_inc;
            phase_nxt = (bc_inc >= limit) ? PH_IGNORE : PH_DATA_START;
          end
        end
        PH_IGNORE: begin
        end
        default: begin
        end
      endcase
    end

    if (accept && in_ch.end_of_text) begin
      bad = err_nxt || phase_nxt == PH_ID || phase_nxt == PH_FD_FLAGS ||
            phase_nxt == PH_DATA_LOW;
      len_round = {1'b0, bc_nxt} + WORD_BYTES_M1;
      if (!bad) begin
        desc.status    = (kind_nxt == KIND_FD) ? ST_FD : ST_CLASSIC;
        desc.can_id    = id_nxt;
        desc.frame_len = bc_nxt;
        desc.fd_flags  = flags_nxt;
        desc.nwords    = (kind_nxt == KIND_REMOTE) ? 4'd0 : len_round[6:3];
      end
      desc.bank  = bank_r;
      desc_valid = 1'b1;
      // start over on the other bank
      phase_nxt  = PH_ID;
      kind_nxt   = KIND_CLASSIC;
      pos_nxt    = '0;
      id_nxt     = '0;
      hi_nxt     = '0;
      bc_nxt     = '0;
      flags_nxt  = '0;
      err_nxt    = 1'b0;
      bank_nxt   = !bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID;
      kind_r  <= KIND_CLASSIC;
      pos_r   <= '0;
      id_r    <= '0;
      hi_r    <= '0;
      bc_r    <= '0;
      flags_r <= '0;
      err_r   <= 1'b0;
      bank_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      pos_r   <= pos_nxt;
      id_r    <= id_nxt;
      hi_r    <= hi_nxt;
      bc_r    <= bc_nxt;
      flags_r <= flags_nxt;
      err_r   <= err_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cftp_emitter.sv =====
// ---------------------------------------------------------------------------
// cftp_emitter
// turns finished frames into a header beat and payload word beats
// ---------------------------------------------------------------------------
`default_nettype none

module cftp_emitter
  import cftp_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  frame_desc_t             desc,
  input  wire                     desc_valid,
  output emit_stat_t              stat,
  output logic [STORE_ADDR_W-1:0] rd_addr,
  input  wire [63:0]              rd_data,
  cftp_out_if.source              out_ch
);

  frame_desc_t act_r, act_nxt;
  frame_desc_t hold_r, hold_nxt;
  logic        act_valid_r, act_valid_nxt;
  logic        hold_full_r, hold_full_nxt;
  logic [3:0]  w_r, w_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] can_id_r, can_id_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic        is_data_r, is_data_nxt;
  logic [2:0]  widx_r, widx_nxt;
  logic [63:0] data_r, data_nxt;
  logic        last_r, last_nxt;

  logic        out_free;
  logic        fire;
  logic        done;
  logic [2:0]  idx;
  logic [2:0]  idx_nxt;
  logic [63:0] masked;

  assign out_free = !out_valid_r || out_ch.ready;
  assign fire     = act_valid_r && out_free;
  assign done     = fire && (w_r == act_r.nwords);
  assign idx      = w_r[2:0] - 3'd1;
  // the store read is registered, so address the word of the next cycle
  assign idx_nxt  = w_nxt[2:0] - 3'd1;
  assign rd_addr  = {act_nxt.bank, idx_nxt};

  // bytes past the frame length in the last word read as zero
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      masked[k*8 +: 8] = ({1'b0, idx, 3'(k)} < act_r.frame_len) ? rd_data[k*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    act_nxt       = act_r;
    hold_nxt      = hold_r;
    act_valid_nxt = act_valid_r;
    hold_full_nxt = hold_full_r;
    w_nxt         = w_r;
    status_nxt    = status_r;
    can_id_nxt    = can_id_r;
    len_nxt       = len_r;
    flags_nxt     = flags_r;
    is_data_nxt   = is_data_r;
    widx_nxt      = widx_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (fire) begin
      out_valid_nxt = 1'b1;
      status_nxt    = act_r.status;
      can_id_nxt    = act_r.can_id;
      len_nxt       = act_r.frame_len;
      flags_nxt     = act_r.fd_flags;
      is_data_nxt   = (w_r != 4'd0);
      widx_nxt      = (w_r != 4'd0) ? idx : 3'd0;
      data_nxt      = (w_r != 4'd0) ? masked : 64'd0;
      last_nxt      = (w_r == act_r.nwords);
      w_nxt         = w_r + 4'd1;
    end

    if (!act_valid_r || done) begin
      w_nxt = '0;
      if (hold_full_r) begin
        act_nxt       = hold_r;
        act_valid_nxt = 1'b1;
        hold_nxt      = desc;
        hold_full_nxt = desc_valid;
      end else begin
        act_nxt       = desc;
        act_valid_nxt = desc_valid;
      end
    end else if (desc_valid) begin
      hold_nxt      = desc;
      hold_full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= 1'b0;
      hold_full_r <= 1'b0;
      out_valid_r <= 1'b0;
      w_r         <= '0;
    end else begin
      act_valid_r <= act_valid_nxt;
      hold_full_r <= hold_full_nxt;
      out_valid_r <= out_valid_nxt;
      w_r         <= w_nxt;
    end
    act_r     <= act_nxt;
    hold_r    <= hold_nxt;
    status_r  <= status_nxt;
    can_id_r  <= can_id_nxt;
    len_r     <= len_nxt;
    flags_r   <= flags_nxt;
    is_data_r <= is_data_nxt;
    widx_r    <= widx_nxt;
    data_r    <= data_nxt;
    last_r    <= last_nxt;
  end

  assign stat.act_valid      = act_valid_r;
  assign stat.hold_full      = hold_full_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.can_id       = can_id_r;
  assign out_ch.frame_len    = len_r;
  assign out_ch.fd_flags     = flags_r;
  assign out_ch.is_data_word = is_data_r;
  assign out_ch.word_index   = widx_r;
  assign out_ch.data_word    = data_r;
  assign out_ch.last         = last_r;

endmodule

`default_nettype wire
